FILE: design/tafs_pkg.sv
// Shared widths, constants, types and the arctangent table for the triangle angle block.
package tafs_pkg;

   // Width of the remainders, numerators and denominators in the divider chain.
   localparam int DIV_W = 68;
   // Width of the Q2.60 quotient.
   localparam int QUO_W = 62;
   // Fraction bits produced by the divider, one per cell.
   localparam int FRAC_STEPS = 60;
   // Width of the square root working registers, and the number of root cells.
   localparam int SQ_W = 64;
   localparam int ROOT_STEPS = 32;
   // Rotation cells and the width of the rotation vector and the angle sum.
   localparam int CORDIC_STEPS = 31;
   localparam int CW = 36;
   localparam int ZW = 36;

   // Stages from the input ports to the last rotation cell, and to the lane output.
   localparam int SAT_DEPTH = 3 + FRAC_STEPS + ROOT_STEPS + CORDIC_STEPS;
   localparam int LANE_LATENCY = SAT_DEPTH + 1;

   // Pi in Q30.
   localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

   typedef logic [DIV_W-1:0]        tafs_wide_type;
   typedef logic [QUO_W-1:0]        tafs_quo_type;
   typedef logic [SQ_W-1:0]         tafs_root_type;
   typedef logic signed [CW-1:0]    tafs_vec_type;
   typedef logic signed [ZW-1:0]    tafs_ang_type;

   // Saturation status of one angle: cosine above one, cosine below minus one.
   typedef struct packed {
      logic lo;
      logic hi;
   } tafs_sat_type;

   // atan(2^-i) in Q30, rounded to nearest.
   function automatic tafs_ang_type atan_q30(input int i);
      tafs_ang_type v;
      unique case (i)
         0:       v = 36'sd843314857;
         1:       v = 36'sd497837829;
         2:       v = 36'sd263043837;
         3:       v = 36'sd133525159;
         4:       v = 36'sd67021687;
         5:       v = 36'sd33543516;
         6:       v = 36'sd16775851;
         7:       v = 36'sd8388437;
         8:       v = 36'sd4194283;
         9:       v = 36'sd2097149;
         default: v = (i >= 10 && i <= 30) ? (36'sd1 <<< (30 - i)) : '0;
      endcase
      return v;
   endfunction

endpackage

FILE: design/tafs_div_cell.sv
// One restoring division cell: produces one quotient bit per cycle while en is high.
module tafs_div_cell (
   input  logic                   clock,
   input  logic                   en,
   input  tafs_pkg::tafs_wide_type rem_in,
   input  tafs_pkg::tafs_wide_type den_in,
   input  tafs_pkg::tafs_quo_type  quo_in,
   output tafs_pkg::tafs_wide_type rem_out,
   output tafs_pkg::tafs_wide_type den_out,
   output tafs_pkg::tafs_quo_type  quo_out
);
   import tafs_pkg::*;

   tafs_wide_type shifted;
   logic          take;
   tafs_wide_type rem_ff;
   tafs_wide_type den_ff;
   tafs_quo_type  quo_ff;

   assign shifted = {rem_in[DIV_W-2:0], 1'b0};
   assign take    = (shifted >= den_in);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= take ? (shifted - den_in) : shifted;
         den_ff <= den_in;
         quo_ff <= {quo_in[QUO_W-2:0], take};
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule

FILE: design/tafs_sqrt_cell.sv
// One integer square root cell: settles one bit of the root per cycle while en is high.
module tafs_sqrt_cell #(
   parameter int K = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  tafs_pkg::tafs_root_type x_in,
   input  tafs_pkg::tafs_root_type res_in,
   output tafs_pkg::tafs_root_type x_out,
   output tafs_pkg::tafs_root_type res_out
);
   import tafs_pkg::*;

   localparam tafs_root_type BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - K));

   tafs_root_type trial;
   logic          take;
   tafs_root_type x_ff;
   tafs_root_type res_ff;

   assign trial = res_in + BIT;
   assign take  = (x_in >= trial);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= take ? (x_in - trial) : x_in;
         res_ff <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
      end
   end

   assign x_out   = x_ff;
   assign res_out = res_ff;

endmodule

FILE: design/tafs_cordic_cell.sv
// One vectoring rotation cell: drives y toward zero and accumulates the angle.
module tafs_cordic_cell #(
   parameter int I = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  tafs_pkg::tafs_vec_type x_in,
   input  tafs_pkg::tafs_vec_type y_in,
   input  tafs_pkg::tafs_ang_type z_in,
   output tafs_pkg::tafs_vec_type x_out,
   output tafs_pkg::tafs_vec_type y_out,
   output tafs_pkg::tafs_ang_type z_out
);
   import tafs_pkg::*;

   localparam tafs_ang_type ATAN = atan_q30(I);

   tafs_vec_type xs;
   tafs_vec_type ys;
   tafs_vec_type x_ff;
   tafs_vec_type y_ff;
   tafs_ang_type z_ff;

   assign xs = x_in >>> I;
   assign ys = y_in >>> I;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!y_in[CW-1]) begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            z_ff <= z_in + ATAN;
         end else begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            z_ff <= z_in - ATAN;
         end
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

FILE: design/tafs_lane.sv
// One angle lane: side terms, products, divider, square root and rotation chains.
module tafs_lane #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [31:0]                   side_o,
   input  logic [31:0]                   side_p,
   input  logic [31:0]                   side_q,
   output logic [ANGLE_FRAC_BITS+1:0]    angle,
   output logic                          sat
);
   import tafs_pkg::*;

   localparam int ANGLE_W = ANGLE_FRAC_BITS + 2;
   localparam int SH = 30 - ANGLE_FRAC_BITS;
   localparam tafs_ang_type HALF = ZW'(1) << (SH - 1);
   localparam logic [ANGLE_W-1:0] PI_ROUND = ANGLE_W'((PI_Q30 + HALF) >>> SH);

   // First stage: differences and sums of the sides.
   logic [31:0] d;
   logic [32:0] s;
   logic [31:0] a1_ff;
   logic [32:0] b1_ff;
   logic [32:0] a2_ff;
   logic [33:0] b2_ff;
   logic [31:0] p_ff;
   logic [31:0] q_ff;
   tafs_sat_type sat_ff [0:SAT_DEPTH-1];

   assign d = (side_p > side_q) ? (side_p - side_q) : (side_q - side_p);
   assign s = {1'b0, side_p} + {1'b0, side_q};

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff        <= side_o - d;
         b1_ff        <= {1'b0, side_o} + {1'b0, d};
         a2_ff        <= s - {1'b0, side_o};
         b2_ff        <= {1'b0, s} + {2'b0, side_o};
         p_ff         <= side_p;
         q_ff         <= side_q;
         sat_ff[0].lo <= (d > side_o);
         sat_ff[0].hi <= (s < {1'b0, side_o});
         for (int m = 1; m < SAT_DEPTH; m++) begin
            sat_ff[m] <= sat_ff[m-1];
         end
      end
   end

   // Second stage: numerators (o-d)(o+d), (p+q-o)(p+q+o) and the denominator 2pq.
   logic [64:0]   m1;
   logic [66:0]   m2;
   logic [63:0]   md;
   tafs_wide_type n_ff [0:1];
   tafs_wide_type den_ff;

   assign m1 = 65'(a1_ff) * 65'(b1_ff);
   assign m2 = 67'(a2_ff) * 67'(b2_ff);
   assign md = 64'(p_ff) * 64'(q_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= DIV_W'(m1);
         n_ff[1] <= DIV_W'(m2);
         den_ff  <= DIV_W'({md, 1'b0});
      end
   end

   // Third stage: integer part of each ratio, then one fraction bit per cell.
   tafs_wide_type rem_c [0:1][0:FRAC_STEPS];
   tafs_wide_type den_c [0:1][0:FRAC_STEPS];
   tafs_quo_type  quo_c [0:1][0:FRAC_STEPS];
   tafs_root_type x_c   [0:1][0:ROOT_STEPS];
   tafs_root_type res_c [0:1][0:ROOT_STEPS];

   for (genvar j = 0; j < 2; j++) begin : g_ratio
      tafs_wide_type den2;
      logic          ge1;
      logic          ge2;
      tafs_wide_type rem_ff;
      tafs_wide_type dcopy_ff;
      tafs_quo_type  quo_ff;

      assign den2 = {den_ff[DIV_W-2:0], 1'b0};
      assign ge2  = (n_ff[j] >= den2);
      assign ge1  = (n_ff[j] >= den_ff);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff   <= ge2 ? (n_ff[j] - den2) : (ge1 ? (n_ff[j] - den_ff) : n_ff[j]);
            quo_ff   <= ge2 ? QUO_W'(2) : (ge1 ? QUO_W'(1) : QUO_W'(0));
            dcopy_ff <= den_ff;
         end
      end

      assign rem_c[j][0] = rem_ff;
      assign den_c[j][0] = dcopy_ff;
      assign quo_c[j][0] = quo_ff;

      for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_div
         tafs_div_cell u_cell (
            .clock   (clock),
            .en      (en),
            .rem_in  (rem_c[j][k]),
            .den_in  (den_c[j][k]),
            .quo_in  (quo_c[j][k]),
            .rem_out (rem_c[j][k+1]),
            .den_out (den_c[j][k+1]),
            .quo_out (quo_c[j][k+1])
         );
      end

      // Floor square root of the Q60 ratio gives a Q30 vector component.
      assign x_c[j][0]   = SQ_W'(quo_c[j][FRAC_STEPS]);
      assign res_c[j][0] = '0;

      for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
         tafs_sqrt_cell #(.K(k)) u_cell (
            .clock   (clock),
            .en      (en),
            .x_in    (x_c[j][k]),
            .res_in  (res_c[j][k]),
            .x_out   (x_c[j][k+1]),
            .res_out (res_c[j][k+1])
         );
      end
   end

   // Half angle is atan2(sqrt(1 - cos), sqrt(1 + cos)) up to a common scale.
   tafs_vec_type cx [0:CORDIC_STEPS];
   tafs_vec_type cy [0:CORDIC_STEPS];
   tafs_ang_type cz [0:CORDIC_STEPS];

   assign cx[0] = {(CW-32)'(0), res_c[1][ROOT_STEPS][31:0]};
   assign cy[0] = {(CW-32)'(0), res_c[0][ROOT_STEPS][31:0]};
   assign cz[0] = '0;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      tafs_cordic_cell #(.I(k)) u_cell (
         .clock (clock),
         .en    (en),
         .x_in  (cx[k]),
         .y_in  (cy[k]),
         .z_in  (cz[k]),
         .x_out (cx[k+1]),
         .y_out (cy[k+1]),
         .z_out (cz[k+1])
      );
   end

   // Final stage: double, clamp to [0, pi], round half up to the output format; a saturated lane gives zero or pi.
   tafs_ang_type       ang2;
   tafs_ang_type       clamped;
   tafs_ang_type       rounded;
   tafs_sat_type       sat_last;
   logic [ANGLE_W-1:0] angle_ff;
   logic               sat_out_ff;

   assign ang2     = {cz[CORDIC_STEPS][ZW-2:0], 1'b0};
   assign clamped  = ang2[ZW-1] ? '0 : ((ang2 > PI_Q30) ? PI_Q30 : ang2);
   assign rounded  = (clamped + HALF) >>> SH;
   assign sat_last = sat_ff[SAT_DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         if (sat_last.lo) begin
            angle_ff <= '0;
         end else if (sat_last.hi) begin
            angle_ff <= PI_ROUND;
         end else begin
            angle_ff <= rounded[ANGLE_W-1:0];
         end
         sat_out_ff <= sat_last.lo | sat_last.hi;
      end
   end

   assign angle = angle_ff;
   assign sat   = sat_out_ff;

endmodule

FILE: design/triangle_angles_from_sides.sv
// Top level of the triangle angle block: three angle lanes, control line and output skid.
// Throughput: one transaction per cycle while req_stall is low; every divider, root and rotation cell is pipelined.
// The result channel has an output register plus one skid entry; req_stall rises only when both are full.
// Reset (synchronous, active high) empties the pipeline, the output register and the skid entry.
module triangle_angles_from_sides #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_side_a,
   input  logic [31:0]                 req_side_b,
   input  logic [31:0]                 req_side_c,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ANGLE_FRAC_BITS+1:0]  rsp_angle_a,
   output logic [ANGLE_FRAC_BITS+1:0]  rsp_angle_b,
   output logic [ANGLE_FRAC_BITS+1:0]  rsp_angle_c,
   output logic                        rsp_degenerate
);
   import tafs_pkg::*;

   localparam int ANGLE_W = ANGLE_FRAC_BITS + 2;
   localparam int LAT = LANE_LATENCY;

   // The whole pipeline advances together; it only freezes while the skid entry is occupied.
   logic en;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Valid bits and the zero-side flag travel alongside the lanes.
   logic vld_ff  [0:LAT-1];
   logic zero_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < LAT; m++) begin
            vld_ff[m] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int m = 1; m < LAT; m++) begin
            vld_ff[m] <= vld_ff[m-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (req_side_a == '0) || (req_side_b == '0) || (req_side_c == '0);
         for (int m = 1; m < LAT; m++) begin
            zero_ff[m] <= zero_ff[m-1];
         end
      end
   end

   // Each lane sees the opposite side first, then the two adjacent sides.
   logic [ANGLE_W-1:0] lane_a;
   logic [ANGLE_W-1:0] lane_b;
   logic [ANGLE_W-1:0] lane_c;
   logic               sat_a;
   logic               sat_b;
   logic               sat_c;

   tafs_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_a (
      .clock  (clock),
      .en     (en),
      .side_o (req_side_a),
      .side_p (req_side_b),
      .side_q (req_side_c),
      .angle  (lane_a),
      .sat    (sat_a)
   );

   tafs_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_b (
      .clock  (clock),
      .en     (en),
      .side_o (req_side_b),
      .side_p (req_side_a),
      .side_q (req_side_c),
      .angle  (lane_b),
      .sat    (sat_b)
   );

   tafs_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_c (
      .clock  (clock),
      .en     (en),
      .side_o (req_side_c),
      .side_p (req_side_a),
      .side_q (req_side_b),
      .angle  (lane_c),
      .sat    (sat_c)
   );

   // A zero side overrides every lane: all angles zero and the flag set.
   logic               last_v;
   logic               last_zero;
   logic [ANGLE_W-1:0] res_a;
   logic [ANGLE_W-1:0] res_b;
   logic [ANGLE_W-1:0] res_c;
   logic               res_flag;

   assign last_v    = vld_ff[LAT-1];
   assign last_zero = zero_ff[LAT-1];
   assign res_a     = last_zero ? '0 : lane_a;
   assign res_b     = last_zero ? '0 : lane_b;
   assign res_c     = last_zero ? '0 : lane_c;
   assign res_flag  = last_zero | sat_a | sat_b | sat_c;

   // Output register and skid entry. A finished transaction goes to the output register
   // when it is free or being taken, and into the skid entry otherwise.
   logic               out_v_ff;
   logic [ANGLE_W-1:0] out_a_ff;
   logic [ANGLE_W-1:0] out_b_ff;
   logic [ANGLE_W-1:0] out_c_ff;
   logic               out_f_ff;
   logic [ANGLE_W-1:0] skid_a_ff;
   logic [ANGLE_W-1:0] skid_b_ff;
   logic [ANGLE_W-1:0] skid_c_ff;
   logic               skid_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (last_v) begin
         if (!out_v_ff || !rsp_stall) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_a_ff <= skid_a_ff;
            out_b_ff <= skid_b_ff;
            out_c_ff <= skid_c_ff;
            out_f_ff <= skid_f_ff;
         end
      end else if (last_v) begin
         if (!out_v_ff || !rsp_stall) begin
            out_a_ff <= res_a;
            out_b_ff <= res_b;
            out_c_ff <= res_c;
            out_f_ff <= res_flag;
         end else begin
            skid_a_ff <= res_a;
            skid_b_ff <= res_b;
            skid_c_ff <= res_c;
            skid_f_ff <= res_flag;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_angle_a    = out_a_ff;
   assign rsp_angle_b    = out_b_ff;
   assign rsp_angle_c    = out_c_ff;
   assign rsp_degenerate = out_f_ff;

   // The skid entry only holds a transaction behind a waiting one in the output register.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry occupied while the output register is empty");

   // The skid entry fills only when the output register was stalled.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid entry filled without a stalled output transaction");

   // A flagged-free result never carries an angle a above pi.
   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (rsp_angle_a <= ANGLE_W'(((PI_Q30 >>> (29 - ANGLE_FRAC_BITS)) + 1) >>> 1)))
      else $error("angle above pi without the degenerate flag");

endmodule
